>>> design/qth_pkg.sv
`default_nettype none
package qth_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int QW = 15;
  localparam int MW = 33;
  localparam int AW = 36;
  localparam int HW = 15;
  localparam int SH = 18;
  localparam int FULL = 23040;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef enum logic [1:0] {
    RC_BOAT    = 2'd0,
    RC_MOTION  = 2'd1,
    RC_UNKNOWN = 2'd2
  } result_code_e;

  typedef enum logic [1:0] {
    KIND_GAME   = 2'd0,
    KIND_GEO    = 2'd1,
    KIND_STAB   = 2'd2,
    KIND_OTHER  = 2'd3
  } report_kind_e;

  typedef struct packed {
    logic [1:0]                code;
    logic signed [QW-1:0]      q_real;
    logic signed [QW-1:0]      q_i;
    logic signed [QW-1:0]      q_j;
    logic signed [QW-1:0]      q_k;
    logic [15:0]               accuracy;
    logic [1:0]                calibration;
  } front_req_t;

  typedef struct packed {
    logic [1:0]   code;
    logic [15:0]  accuracy;
    logic [1:0]   calibration;
  } tag_t;

  function automatic logic signed [AW-1:0] atan_deg(input int s);
    logic signed [AW-1:0] v;
    begin
      case (s)
        0: v = 36'sd754974720;
        1: v = 36'sd445687602;
        2: v = 36'sd235489088;
        3: v = 36'sd119537938;
        4: v = 36'sd60000934;
        5: v = 36'sd30029717;
        6: v = 36'sd15018523;
        7: v = 36'sd7509720;
        8: v = 36'sd3754917;
        9: v = 36'sd1877466;
        10: v = 36'sd938734;
        11: v = 36'sd469367;
        12: v = 36'sd234684;
        13: v = 36'sd117342;
        14: v = 36'sd58671;
        15: v = 36'sd29335;
        16: v = 36'sd14668;
        17: v = 36'sd7334;
        18: v = 36'sd3667;
        19: v = 36'sd1833;
        20: v = 36'sd917;
        21: v = 36'sd458;
        22: v = 36'sd229;
        default: v = 36'sd115;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> design/quaternion_to_heading.sv
// channel   | direction | handshake
// report    | in        | push_i / full_o
// result    | out       | pop_i  / empty_o
// config    | in        | cfg_valid_i / cfg_ready_o (always ready)
// One report per cycle sustained while the result queue can drain; a report
// passes the front queue, the multiply, sum, pre-rotate, CORDIC, round and
// wrap stages, and the result queue.
// Reset clears queue counts and valid bits; correction resets to zero.
// A full result queue with no pop stalls the pipeline once a result waits at its end; the front queue absorbs input.
`default_nettype none
module quaternion_to_heading (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [1:0]         report_kind_i,
  input  wire logic signed [14:0] q_real_i,
  input  wire logic signed [14:0] q_i_i,
  input  wire logic signed [14:0] q_j_i,
  input  wire logic signed [14:0] q_k_i,
  input  wire logic [15:0]        accuracy_in_i,
  input  wire logic [1:0]         calibration_in_i,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic [1:0]              result_code_o,
  output logic [14:0]             heading_o,
  output logic [15:0]             accuracy_out_o,
  output logic [1:0]              calibration_out_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic signed [8:0]  heading_correction_i
);

  logic req_valid, req_ready;
  qth_pkg::front_req_t req;

  qth_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .report_kind_i, .q_real_i, .q_i_i,
    .q_j_i, .q_k_i, .accuracy_in_i, .calibration_in_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  qth_back u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i(heading_correction_i), .req_valid_i(req_valid),
    .req_ready_o(req_ready), .req_i(req), .empty_o, .pop_i,
    .result_code_o, .heading_o, .accuracy_out_o, .calibration_out_o
  );

endmodule
`default_nettype wire

>>> design/qth_front.sv
`default_nettype none
module qth_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  output logic                        full_o,
  input  wire logic [1:0]             report_kind_i,
  input  wire logic signed [14:0]     q_real_i,
  input  wire logic signed [14:0]     q_i_i,
  input  wire logic signed [14:0]     q_j_i,
  input  wire logic signed [14:0]     q_k_i,
  input  wire logic [15:0]            accuracy_in_i,
  input  wire logic [1:0]             calibration_in_i,
  output logic                        req_valid_o,
  input  wire logic                   req_ready_i,
  output qth_pkg::front_req_t         req_o
);

  qth_pkg::front_req_t mem_q [qth_pkg::QDEPTH];
  logic [qth_pkg::QAW:0] cnt_q, cnt_d;
  logic [qth_pkg::QAW-1:0] wp_q, rp_q;
  qth_pkg::front_req_t cls;
  logic wr, rd;

  always_comb begin
    cls.q_real = q_real_i;
    cls.q_i = q_i_i;
    cls.q_j = q_j_i;
    cls.q_k = q_k_i;
    cls.accuracy = accuracy_in_i;
    cls.calibration = calibration_in_i;
    case (qth_pkg::report_kind_e'(report_kind_i))
      qth_pkg::KIND_GAME, qth_pkg::KIND_GEO: cls.code = qth_pkg::RC_BOAT;
      qth_pkg::KIND_STAB: begin
        cls.code = qth_pkg::RC_MOTION;
        cls.accuracy = '0;
        cls.calibration = '0;
      end
      default: begin
        cls.code = qth_pkg::RC_UNKNOWN;
        cls.accuracy = '0;
        cls.calibration = '0;
      end
    endcase
  end

  assign full_o = (cnt_q == (qth_pkg::QAW+1)'(qth_pkg::QDEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o = mem_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = req_valid_o && req_ready_i;
  assign cnt_d = cnt_q + {{qth_pkg::QAW{1'b0}}, wr} - {{qth_pkg::QAW{1'b0}}, rd};

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> design/qth_back.sv
`default_nettype none
module qth_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic signed [8:0]      cfg_data_i,
  input  wire logic                   req_valid_i,
  output logic                        req_ready_o,
  input  wire qth_pkg::front_req_t    req_i,
  output logic                        empty_o,
  input  wire logic                   pop_i,
  output logic [1:0]                  result_code_o,
  output logic [14:0]                 heading_o,
  output logic [15:0]                 accuracy_out_o,
  output logic [1:0]                  calibration_out_o
);

  localparam int N = qth_pkg::CORDIC_STAGES;
  localparam int AW = qth_pkg::AW;
  localparam int MW = qth_pkg::MW;
  localparam int HW = qth_pkg::HW;
  // total stages: 1 mult, 1 sum, 1 pre, N cordic, 1 round, 1 wrap
  localparam int L = N + 5;

  logic adv;
  logic [L-1:0] v_q;
  qth_pkg::tag_t tag_q [L];

  // out skid queue of depth 2 after pipe
  logic [1:0] ocnt_q;

  logic signed [9:0] corr_q;
  assign cfg_ready_o = 1'b1;

  // product stage
  logic signed [29:0] pjj_q, pkk_q, pij_q, prk_q;
  // sum stage
  logic signed [MW-1:0] x0_q, y0_q;
  // cordic
  logic signed [MW+1:0] x_q [N+1];
  logic signed [MW+1:0] y_q [N+1];
  logic signed [AW-1:0] z_q [N+1];
  logic signed [HW+2:0] hs_q;
  logic [HW-1:0] hf_q;

  // stall the whole pipe only when results cannot be drained
  assign adv = !(v_q[L-1] && ocnt_q == 2'd2 && !(pop_i && !empty_o)) ;
  assign req_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= '0;
      v_q <= '0;
    end else begin
      if (cfg_valid_i) corr_q <= 10'(cfg_data_i);
      if (adv) v_q <= {v_q[L-2:0], req_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[0] <= '{req_i.code, req_i.accuracy, req_i.calibration};
      for (int i = 1; i < L; i++) tag_q[i] <= tag_q[i-1];
      pjj_q <= req_i.q_j * req_i.q_j;
      pkk_q <= req_i.q_k * req_i.q_k;
      pij_q <= req_i.q_i * req_i.q_j;
      prk_q <= req_i.q_real * req_i.q_k;
      x0_q <= (MW'(1) <<< 28) - ((MW'(pjj_q) + MW'(pkk_q)) <<< 1);
      y0_q <= -((MW'(pij_q) + MW'(prk_q)) <<< 1);
      if (x0_q == '0 && y0_q == '0) begin
        x_q[0] <= '0;
        y_q[0] <= '0;
        z_q[0] <= '0;
      end else if (x0_q < 0) begin
        x_q[0] <= -(MW+2)'(x0_q);
        y_q[0] <= -(MW+2)'(y0_q);
        z_q[0] <= (y0_q >= 0) ? (AW'(180) <<< 24) : -(AW'(180) <<< 24);
      end else begin
        x_q[0] <= (MW+2)'(x0_q);
        y_q[0] <= (MW+2)'(y0_q);
        z_q[0] <= '0;
      end
      for (int s = 0; s < N; s++) begin
        if (x_q[s] == '0 && y_q[s] == '0) begin
          x_q[s+1] <= x_q[s];
          y_q[s+1] <= y_q[s];
          z_q[s+1] <= z_q[s];
        end else if (y_q[s] >= 0) begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + qth_pkg::atan_deg(s);
        end else begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - qth_pkg::atan_deg(s);
        end
      end
      hs_q <= (HW+3)'((z_q[N] + (AW'(corr_q) <<< 24)
              + (AW'(1) <<< (qth_pkg::SH-1))) >>> qth_pkg::SH);
      begin
        logic signed [HW+2:0] h;
        h = hs_q;
        if (h >= (HW+3)'(qth_pkg::FULL)) h = h - (HW+3)'(qth_pkg::FULL);
        if (h >= (HW+3)'(qth_pkg::FULL)) h = h - (HW+3)'(qth_pkg::FULL);
        if (h < 0) h = h + (HW+3)'(qth_pkg::FULL);
        if (h < 0) h = h + (HW+3)'(qth_pkg::FULL);
        hf_q <= (tag_q[L-2].code == qth_pkg::RC_UNKNOWN) ? '0 : h[HW-1:0];
      end
    end
  end

  // output queue, depth 2
  typedef struct packed {
    qth_pkg::tag_t t;
    logic [HW-1:0] h;
  } res_t;
  res_t oq_q [2];
  res_t nin;
  logic owr, ord;
  assign nin = '{tag_q[L-1], hf_q};
  assign owr = v_q[L-1] && adv;
  assign ord = pop_i && !empty_o;
  assign empty_o = (ocnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ocnt_q <= '0;
    else ocnt_q <= ocnt_q + 2'(owr) - 2'(ord);
  end

  always_ff @(posedge clk_i) begin
    if (ord) begin
      oq_q[0] <= oq_q[1];
      if (owr && ocnt_q == 2'd2) oq_q[1] <= nin;
      if (owr && ocnt_q == 2'd1) oq_q[0] <= nin;
    end else if (owr) begin
      if (ocnt_q == 2'd0) oq_q[0] <= nin;
      else oq_q[1] <= nin;
    end
  end

  assign result_code_o = oq_q[0].t.code;
  assign heading_o = oq_q[0].h;
  assign accuracy_out_o = oq_q[0].t.accuracy;
  assign calibration_out_o = oq_q[0].t.calibration;

endmodule
`default_nettype wire

>>> design/qth_checker.sv
`default_nettype none
module qth_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [1:0]  result_code_o,
  input wire logic [14:0] heading_o,
  input wire logic [15:0] accuracy_out_o,
  input wire logic [1:0]  calibration_out_o
);
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> result_code_o <= qth_pkg::RC_UNKNOWN) else $error("bad code");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> heading_o < 15'(qth_pkg::FULL)) else $error("heading range");
  a_unk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_code_o == qth_pkg::RC_UNKNOWN) |-> heading_o == 15'd0)
    else $error("unknown");
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_code_o != qth_pkg::RC_BOAT) |-> (accuracy_out_o == 16'd0 &&
    calibration_out_o == 2'd0)) else $error("pass");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(heading_o))) else $error("hold");
endmodule

bind quaternion_to_heading qth_checker u_chk (.*);
`default_nettype wire

>>> verif/quaternion_to_heading_checker.sv
`default_nettype none
module quaternion_to_heading_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               full_o,
  input  wire logic [1:0]         report_kind_i,
  input  wire logic signed [14:0] q_real_i,
  input  wire logic signed [14:0] q_i_i,
  input  wire logic signed [14:0] q_j_i,
  input  wire logic signed [14:0] q_k_i,
  input  wire logic [15:0]        accuracy_in_i,
  input  wire logic [1:0]         calibration_in_i,
  input  wire logic               empty_o,
  input  wire logic               pop_i,
  input  wire logic [1:0]         result_code_o,
  input  wire logic [14:0]        heading_o,
  input  wire logic [15:0]        accuracy_out_o,
  input  wire logic [1:0]         calibration_out_o,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_o,
  input  wire logic signed [8:0]  heading_correction_i,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  code;
    logic [14:0] heading;
    logic [15:0] accuracy;
    logic [1:0]  calibration;
  } heading_rec_t;

  localparam longint ATAN_TAB [16] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };

  heading_rec_t expected_headings[$];
  logic signed [8:0] correction;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan2_deg(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (longint'(180) <<< 24) : -(longint'(180) <<< 24);
      x = -x;
      y = -y;
    end
    for (int s = 0; s < 16; s++) begin
      dx = floor_shift(y, s);
      dy = floor_shift(x, s);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TAB[s];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TAB[s];
      end
    end
    return z;
  endfunction

  function automatic heading_rec_t predict_heading(logic [1:0] kind, longint qr, longint qi,
                                                    longint qj, longint qk,
                                                    logic [15:0] acc, logic [1:0] cal,
                                                    logic signed [8:0] corr);
    heading_rec_t r;
    longint r11, r21, total, h;
    r = '0;
    if (kind == qth_pkg::KIND_OTHER) begin
      r.code = qth_pkg::RC_UNKNOWN;
      return r;
    end
    r11 = (longint'(1) <<< 28) - 2 * (qj * qj + qk * qk);
    r21 = 2 * (qi * qj + qr * qk);
    total = atan2_deg(r11, -r21) + longint'(corr) * (longint'(1) <<< 24);
    h = floor_shift(total + (longint'(1) <<< 17), 18);
    if (h >= qth_pkg::FULL) h -= qth_pkg::FULL;
    if (h >= qth_pkg::FULL) h -= qth_pkg::FULL;
    if (h < 0) h += qth_pkg::FULL;
    if (h < 0) h += qth_pkg::FULL;
    r.heading = h[14:0];
    if (kind == qth_pkg::KIND_STAB) begin
      r.code = qth_pkg::RC_MOTION;
    end else begin
      r.code = qth_pkg::RC_BOAT;
      r.accuracy = acc;
      r.calibration = cal;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = expected_headings.size();

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    heading_rec_t want;
    if (!rst_ni) begin
      correction <= '0;
      expected_headings.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) correction <= heading_correction_i;
      if (push_i && !full_o)
        expected_headings.push_back(predict_heading(report_kind_i, q_real_i, q_i_i, q_j_i,
                                                    q_k_i, accuracy_in_i, calibration_in_i,
                                                    correction));
      if (pop_i && !empty_o) begin
        if (expected_headings.size() == 0) begin
          report_mismatch("unexpected result", result_code_o, -1);
        end else begin
          want = expected_headings.pop_front();
          if (result_code_o != want.code) report_mismatch("code", result_code_o, want.code);
          if (heading_o != want.heading) report_mismatch("heading", heading_o, want.heading);
          if (accuracy_out_o != want.accuracy)
            report_mismatch("accuracy", accuracy_out_o, want.accuracy);
          if (calibration_out_o != want.calibration)
            report_mismatch("calibration", calibration_out_o, want.calibration);
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> verif/quaternion_to_heading_tb.sv
`default_nettype none
module quaternion_to_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = qth_pkg::CORDIC_STAGES + 6;
  localparam int STALL_LIMIT = 2000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic push_i = 1'b0, pop_i = 1'b0, cfg_valid_i = 1'b0;
  logic full_o, empty_o, cfg_ready_o;
  logic [1:0] report_kind_i = '0, calibration_in_i = '0;
  logic signed [14:0] q_real_i = '0, q_i_i = '0, q_j_i = '0, q_k_i = '0;
  logic [15:0] accuracy_in_i = '0;
  logic signed [8:0] heading_correction_i = '0;
  logic [1:0] result_code_o, calibration_out_o;
  logic [14:0] heading_o;
  logic [15:0] accuracy_out_o;
  int fail_count, pending_count;
  int idle_cycles;
  bit pop_steady;
  bit quiet_tail;

  quaternion_to_heading u_dut (.*);
  quaternion_to_heading_checker u_checker (.*);

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail || pop_steady) pop_i <= 1'b1;
      else if (gap > 0) begin
        gap--;
        pop_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6) - 1;
        pop_i <= 1'b0;
      end else pop_i <= 1'b1;
    end
  end

  task automatic write_correction(logic signed [8:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    heading_correction_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_requests();
    while (pending_count != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_request(logic [1:0] kind, logic signed [14:0] qr, logic signed [14:0] qi,
                              logic signed [14:0] qj, logic signed [14:0] qk,
                              logic [15:0] acc, logic [1:0] cal, bit may_idle);
    if (may_idle && $urandom_range(0, 7) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    push_i <= 1'b1;
    report_kind_i <= kind;
    q_real_i <= qr;
    q_i_i <= qi;
    q_j_i <= qj;
    q_k_i <= qk;
    accuracy_in_i <= acc;
    calibration_in_i <= cal;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  function automatic logic signed [14:0] rand_q(int mode);
    case (mode)
      0: return 15'sh4000;
      1: return 15'sh3fff;
      2: return 15'sd0;
      default: return 15'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [14:0] qv [4];
    real a, b;
    logic signed [8:0] corr_set [6];
    corr_set = '{9'sd0, -9'sd180, 9'sd180, 9'sd255, -9'sd256, 9'sd37};
    quiet_tail = 0;
    pop_steady = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int k = 0; k < 4; k++) begin
      send_request(2'(k), 15'sd16383, 0, 0, 0, 16'hffff, 2'd3, 0);
      send_request(2'(k), 15'sh4000, 15'sh4000, 15'sh4000, 15'sh4000, 16'h0000, 2'd0, 0);
    end
    send_request(qth_pkg::KIND_GAME, 0, 0, 0, 0, 16'h5a5a, 2'd1, 0);
    send_request(qth_pkg::KIND_GAME, 0, 0, 15'sh2d41, 15'sh2d41, 16'ha5a5, 2'd2, 0);
    send_request(qth_pkg::KIND_GEO, 0, 0, 15'sd16383, 0, 16'h1234, 2'd3, 0);
    send_request(qth_pkg::KIND_GEO, 0, 0, 15'sd11585, 0, 16'h1, 2'd3, 0);
    send_request(qth_pkg::KIND_STAB, 15'sd11585, 0, 0, 15'sd11585, 16'h8000, 2'd1, 0);
    send_request(qth_pkg::KIND_STAB, 15'sd11585, 0, 0, -15'sd11585, 16'h7fff, 2'd2, 0);
    send_request(qth_pkg::KIND_GAME, 0, 15'sd11585, 15'sd11585, 0, 16'h0f0f, 2'd0, 0);
    send_request(qth_pkg::KIND_GAME, 0, -15'sd11585, 15'sd11585, 0, 16'hf0f0, 2'd3, 0);
    push_i <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      drain_requests();
      write_correction(corr_set[p]);
      for (int n = 0; n < 255; n++) begin
        if (p == 5 && n > 200) quiet_tail = 1;
        pop_steady = (n % 64) < 12;
        if ($urandom_range(0, 9) < 7) begin
          a = ($urandom_range(0, 62831) / 10000.0);
          b = ($urandom_range(0, 31415) / 10000.0);
          qv[0] = 15'($rtoi(16383.0 * $cos(a / 2) * $cos(b / 2)));
          qv[1] = 15'($rtoi(16383.0 * $sin(b / 2) * $cos(a / 2)));
          qv[2] = 15'($rtoi(16383.0 * $sin(b / 2) * $sin(a / 2)));
          qv[3] = 15'($rtoi(16383.0 * $sin(a / 2) * $cos(b / 2)));
          if ($urandom_range(0, 1)) qv[0] = -qv[0];
        end else begin
          for (int c = 0; c < 4; c++) qv[c] = rand_q($urandom_range(0, 5));
        end
        send_request(2'($urandom), qv[0], qv[1], qv[2], qv[3], 16'($urandom),
                     2'($urandom), !quiet_tail);
      end
      push_i <= 1'b0;
    end
    drain_requests();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
design/qth_pkg.sv
design/qth_front.sv
design/qth_back.sv
design/quaternion_to_heading.sv
design/qth_checker.sv
verif/quaternion_to_heading_checker.sv
verif/quaternion_to_heading_tb.sv
